[src/cbmd_pkg.sv]
// ----------------------------------------------------------------------------
// cbmd_pkg
// Shared types and constants for the color/brightness mask with dilation.
// ----------------------------------------------------------------------------
package cbmd_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_IS_BLUE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd4;

    localparam logic       RST_TARGET_IS_BLUE = 1'b0;
    localparam logic [7:0] RST_COLOR_LEVEL    = 8'd100;
    localparam logic [7:0] RST_BRIGHT_LEVEL   = 8'd100;
    localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT  = 12'd480;

    localparam int GRAY_W     = 22;
    localparam int GRAY_B     = 1868;
    localparam int GRAY_G     = 9617;
    localparam int GRAY_R     = 4899;
    localparam int GRAY_ROUND = 8192;
    localparam int GRAY_SHIFT = 14;

    localparam int WIN       = 5;
    localparam int HIST_ROWS = 4;

    typedef struct packed {
        logic       target_is_blue;
        logic [7:0] color_level;
        logic [7:0] bright_level;
    } thresh_t;

endpackage

[src/cbmd_classify.sv]
// ----------------------------------------------------------------------------
// cbmd_classify
// Per-pixel test: saturated channel difference and weighted gray level,
// both against their thresholds.
// ----------------------------------------------------------------------------
module cbmd_classify (
    input  cbmd_pkg::thresh_t thresh,
    input  logic [7:0]        blue,
    input  logic [7:0]        green,
    input  logic [7:0]        red,
    output logic              hit
);
    import cbmd_pkg::*;

    logic [7:0]        diff;
    logic [GRAY_W-1:0] gray_sum;
    logic [7:0]        gray;

    always_comb begin
        if (thresh.target_is_blue) begin
            diff = (blue > red) ? blue - red : 8'd0;
        end else begin
            diff = (red > blue) ? red - blue : 8'd0;
        end
        gray_sum = GRAY_W'(blue) * GRAY_W'(GRAY_B)
                 + GRAY_W'(green) * GRAY_W'(GRAY_G)
                 + GRAY_W'(red) * GRAY_W'(GRAY_R)
                 + GRAY_W'(GRAY_ROUND);
        gray = gray_sum[GRAY_SHIFT +: 8];
        hit  = (diff > thresh.color_level) && (gray > thresh.bright_level);
    end

endmodule

[src/color_brightness_mask_dilate.sv]
// ----------------------------------------------------------------------------
// color_brightness_mask_dilate
// Color-difference and brightness threshold over a BGR raster stream,
// followed by a 5x5 rectangular dilation of the resulting mask.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one transaction per pixel in raster order, tdata = {R, G, B},
//   tuser = 0 for a pixel, 1 for a flush tick. After the last pixel of a
//   frame send 2*W+2 flush ticks to drain the remaining mask outputs.
//   m_axis: one mask bit per transaction in raster order, tlast on the
//   last pixel of the frame; the frame then restarts at row 0.
//   cfg: register writes (index, data), always ready, only while idle.
//   Writing frame_width or frame_height restarts the frame.
// Throughput: one transaction per clock while the skid register is empty.
// Pipeline: after the transaction that completes its window, a result passes
//   the input register, line-store read, window and output registers. Each
//   output trails its pixel by 2*W+2 input transactions.
// Reset: all positions cleared, registers at their defaults; the line
//   store needs no clearing, rows above the frame top are masked.
// Stall: a skid register holds one result while m_tready is low;
//   s_tready falls only once that is also full.
// ----------------------------------------------------------------------------
module color_brightness_mask_dilate #(
    parameter int MAX_WIDTH  = cbmd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cbmd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // blue, green, red
    input  logic                           s_tuser,   // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // mask, zero pad
    output logic                           m_tlast,   // frame_end
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbmd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cbmd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int WX = WW + 1;
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 4);
    localparam int RX = RW + 1;
    localparam int LW = $clog2(2 * MAX_WIDTH + 3);

    typedef struct packed {
        logic                 real_px;
        logic                 emit;
        logic                 last;
        logic [WIN-1:0]       col_ok;
        logic [WIN-1:0]       row_ok;
        logic [HIST_ROWS-1:0] hist_ok;
        logic [CW-1:0]        col;
    } stage_t;

    logic        target_is_blue_reg;
    logic [7:0]  color_level_reg;
    logic [7:0]  bright_level_reg;
    logic [11:0] frame_width_reg;
    logic [11:0] frame_height_reg;

    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic [LW-1:0] lead_reg;

    logic          v1_reg, v2_reg, v3_reg;
    stage_t        s1_reg, s2_reg;
    logic [7:0]    blue1_reg, green1_reg, red1_reg;
    logic          hit2_reg;
    logic [HIST_ROWS-1:0] hist_rd_reg;
    logic          last3_reg;
    logic [WIN-1:0] col_ok3_reg, row_ok3_reg;
    logic [WIN-1:0][WIN-1:0] win_reg;

    logic [HIST_ROWS-1:0] hist_mem [MAX_WIDTH];

    logic m_valid_reg, m_mask_reg, m_last_reg;
    logic skid_valid_reg, skid_mask_reg, skid_last_reg;

    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [LW-1:0] lag;
    logic          en, take, drop, advance, in_frame, emit_now, last_now;
    logic          in_col_wrap, out_col_wrap, geo_write, cfg_write;
    stage_t        s1_next;
    thresh_t       thresh;
    logic          hit;
    logic [HIST_ROWS-1:0] hist_eff;
    logic [HIST_ROWS-1:0] hist_wr;
    logic [WIN-1:0] colvec;
    logic          mask3;

    always_comb begin
        if (frame_width_reg == '0) begin
            w = WW'(1);
        end else if (int'(frame_width_reg) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h = HW'(1);
        end else if (int'(frame_height_reg) > MAX_HEIGHT) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(frame_height_reg);
        end
        lag = (LW'(w) << 1) + LW'(2);
    end

    assign en        = !skid_valid_reg;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign take      = s_tvalid && s_tready;
    assign in_frame  = in_row_reg < RW'(h);
    assign drop      = in_frame && s_tuser;
    assign advance   = take && !drop;
    assign emit_now  = lead_reg == lag;
    assign in_col_wrap  = WW'(in_col_reg) == w - WW'(1);
    assign out_col_wrap = WW'(out_col_reg) == w - WW'(1);
    assign last_now  = out_col_wrap && (out_row_reg == RW'(h) - RW'(1));
    assign cfg_write = cfg_valid && cfg_ready;
    assign geo_write = cfg_write
                    && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_comb begin
        s1_next.real_px = in_frame;
        s1_next.emit    = emit_now;
        s1_next.last    = emit_now && last_now;
        s1_next.col     = in_col_reg;
        for (int i = 0; i < HIST_ROWS; i++) begin
            s1_next.hist_ok[i] = in_row_reg >= RW'(i + 1);
        end
        s1_next.col_ok[0] = WX'(out_col_reg) + WX'(2) < WX'(w);
        s1_next.col_ok[1] = WX'(out_col_reg) + WX'(1) < WX'(w);
        s1_next.col_ok[2] = 1'b1;
        s1_next.col_ok[3] = out_col_reg >= CW'(1);
        s1_next.col_ok[4] = out_col_reg >= CW'(2);
        s1_next.row_ok[0] = RX'(out_row_reg) + RX'(2) < RX'(h);
        s1_next.row_ok[1] = RX'(out_row_reg) + RX'(1) < RX'(h);
        s1_next.row_ok[2] = 1'b1;
        s1_next.row_ok[3] = out_row_reg >= RW'(1);
        s1_next.row_ok[4] = out_row_reg >= RW'(2);
    end

    assign thresh = '{target_is_blue: target_is_blue_reg,
                      color_level:    color_level_reg,
                      bright_level:   bright_level_reg};

    cbmd_classify u_classify (
        .thresh (thresh),
        .blue   (blue1_reg),
        .green  (green1_reg),
        .red    (red1_reg),
        .hit    (hit)
    );

    assign hist_eff = hist_rd_reg & s2_reg.hist_ok;
    assign hist_wr  = {hist_eff[HIST_ROWS-2:0], hit2_reg & s2_reg.real_px};
    assign colvec   = {hist_eff, hit2_reg & s2_reg.real_px};

    always_comb begin
        mask3 = 1'b0;
        for (int j = 0; j < WIN; j++) begin
            for (int k = 0; k < WIN; k++) begin
                mask3 = mask3 | (win_reg[j][k] & col_ok3_reg[j] & row_ok3_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_is_blue_reg <= RST_TARGET_IS_BLUE;
            color_level_reg    <= RST_COLOR_LEVEL;
            bright_level_reg   <= RST_BRIGHT_LEVEL;
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_TARGET_IS_BLUE: target_is_blue_reg <= cfg_data[0];
                REG_COLOR_LEVEL:    color_level_reg    <= cfg_data[7:0];
                REG_BRIGHT_LEVEL:   bright_level_reg   <= cfg_data[7:0];
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[11:0];
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lead_reg    <= '0;
        end else if (geo_write || (advance && emit_now && last_now)) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lead_reg    <= '0;
        end else if (advance) begin
            if (in_col_wrap) begin
                in_col_reg <= '0;
                in_row_reg <= in_row_reg + RW'(1);
            end else begin
                in_col_reg <= in_col_reg + CW'(1);
            end
            if (!emit_now) begin
                lead_reg <= lead_reg + LW'(1);
            end else if (out_col_wrap) begin
                out_col_reg <= '0;
                out_row_reg <= out_row_reg + RW'(1);
            end else begin
                out_col_reg <= out_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            win_reg <= '0;
        end else if (en) begin
            v1_reg <= advance;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && s2_reg.emit;
            if (v2_reg) begin
                win_reg <= {win_reg[WIN-2:0], colvec};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg      <= s1_next;
            blue1_reg   <= s_tdata[7:0];
            green1_reg  <= s_tdata[15:8];
            red1_reg    <= s_tdata[23:16];
            s2_reg      <= s1_reg;
            hit2_reg    <= hit;
            last3_reg   <= s2_reg.last;
            col_ok3_reg <= s2_reg.col_ok;
            row_ok3_reg <= s2_reg.row_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && v2_reg) begin
            hist_mem[s2_reg.col] <= hist_wr;
        end
        if (en) begin
            if (v2_reg && s2_reg.col == s1_reg.col) begin
                hist_rd_reg <= hist_wr;
            end else begin
                hist_rd_reg <= hist_mem[s1_reg.col];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                m_mask_reg     <= skid_mask_reg;
                m_last_reg     <= skid_last_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (v3_reg) begin
            if (!m_valid_reg || m_tready) begin
                m_mask_reg  <= mask3;
                m_last_reg  <= last3_reg;
                m_valid_reg <= 1'b1;
            end else begin
                skid_mask_reg  <= mask3;
                skid_last_reg  <= last3_reg;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_mask_reg};
    assign m_tlast  = m_last_reg;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid)
        else $error("skid holds a result while the output register is empty");

    a_skid_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> $past(m_tvalid && !m_tready))
        else $error("skid filled without an output stall");

    a_lead_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lead_reg <= lag)
        else $error("lead count ran past the output lag");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(in_row_reg) <= int'(h) + 3)
        else $error("input row ran past the drain region");

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for color_brightness_mask_dilate: drives BGR pixels and
// flush ticks in raster order, predicts every mask bit and frame end from a
// behavioral copy of the threshold and 5x5 dilation, and compares each output
// transaction against the oldest prediction under random idling and stalls.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbmd_pkg::*;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int LINE_MAX     = 2048;
    localparam int ROWS_MAX     = 2048;
    localparam int HIST_DEPTH   = 8;
    localparam int WT_BLUE      = 1868;
    localparam int WT_GREEN     = 9617;
    localparam int WT_RED       = 4899;
    localparam int GRAY_HALF    = 8192;
    localparam int GRAY_FRAC    = 14;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 400_000;

    typedef struct packed {
        logic mask;
        logic frame_end;
    } mask_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic        want_blue    = 1'b0;
    logic [7:0]  color_thresh = 8'd100;
    logic [7:0]  bright_thresh = 8'd100;
    logic [11:0] geo_width    = 12'd640;
    logic [11:0] geo_height   = 12'd480;
    bit          mask_hist [HIST_DEPTH][LINE_MAX];
    int unsigned in_row, in_col, out_row, out_col;

    mask_result_t mask_expect_q[$];
    mask_result_t oldest;
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           hold_off      = 0;

    color_brightness_mask_dilate dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned line_width();
        if (geo_width == 12'd0) return 1;
        if (geo_width > LINE_MAX) return LINE_MAX;
        return geo_width;
    endfunction

    function automatic int unsigned frame_rows();
        if (geo_height == 12'd0) return 1;
        if (geo_height > ROWS_MAX) return ROWS_MAX;
        return geo_height;
    endfunction

    function automatic void restart_raster();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic logic pixel_hit(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        int diff;
        int gray;
        if (want_blue) diff = (b > r) ? int'(b) - int'(r) : 0;
        else diff = (r > b) ? int'(r) - int'(b) : 0;
        gray = (WT_BLUE * int'(b) + WT_GREEN * int'(g) + WT_RED * int'(r) + GRAY_HALF)
               >> GRAY_FRAC;
        return (diff > int'(color_thresh)) && (gray > int'(bright_thresh));
    endfunction

    function automatic logic dilate_window(int w, int h);
        int   rr;
        int   cc;
        logic hit;
        hit = 1'b0;
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                rr = int'(out_row) + dr;
                cc = int'(out_col) + dc;
                if (rr >= 0 && rr < h && cc >= 0 && cc < w) begin
                    if (mask_hist[rr % HIST_DEPTH][cc]) hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    function automatic void predict_mask(logic op, logic [23:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  pos;
        mask_result_t res;
        w = line_width();
        h = frame_rows();
        if (in_row < h) begin
            if (op == OP_FLUSH) return;
            mask_hist[in_row % HIST_DEPTH][in_col] = pixel_hit(px[7:0], px[15:8], px[23:16]);
        end
        pos = in_row * w + in_col;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (pos < 2 * w + 2) return;
        res.mask      = dilate_window(w, h);
        res.frame_end = (out_row == h - 1) && (out_col == w - 1);
        mask_expect_q.push_back(res);
        if (res.frame_end) begin
            restart_raster();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_TARGET_IS_BLUE: want_blue = val[0];
            REG_COLOR_LEVEL:    color_thresh = val[7:0];
            REG_BRIGHT_LEVEL:   bright_thresh = val[7:0];
            REG_FRAME_WIDTH: begin
                geo_width = val;
                restart_raster();
            end
            REG_FRAME_HEIGHT: begin
                geo_height = val;
                restart_raster();
            end
            default: ;
        endcase
    endfunction

    function automatic logic [23:0] random_pixel();
        logic [7:0] hot;
        logic [7:0] cold;
        logic [7:0] mid;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            hot  = 8'($urandom_range(255, 150));
            cold = 8'($urandom_range(60));
            mid  = 8'($urandom_range(255, 100));
            return want_blue ? {cold, mid, hot} : {hot, mid, cold};
        end
        if (pick < 30) return 24'($urandom);
        return {8'($urandom_range(80)), 8'($urandom_range(80)), 8'($urandom_range(80))};
    endfunction

    // receiver: random stalls, or a counted hold-off when requested
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off = hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (mask_expect_q.size() == 0) begin
                $error("unexpected transaction: mask %0d frame_end %0d", m_tdata[0], m_tlast);
                error_count++;
            end else begin
                oldest = mask_expect_q.pop_front();
                if (m_tdata[0] !== oldest.mask) begin
                    $error("mask mismatch: expected %0d, actual %0d", oldest.mask, m_tdata[0]);
                    error_count++;
                end
                if (m_tlast !== oldest.frame_end) begin
                    $error("frame_end mismatch: expected %0d, actual %0d",
                           oldest.frame_end, m_tlast);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(logic op, logic [23:0] px);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        predict_mask(op, px);
    endtask

    // hold the input idle until every predicted result is out, then settle
    task automatic drain(int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (mask_expect_q.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic blue, logic [7:0] clvl, logic [7:0] blvl,
                             logic [11:0] wraw, logic [11:0] hraw);
        drain(SETTLE_CYCLES);
        write_reg(REG_TARGET_IS_BLUE, CFG_DATA_W'(blue));
        write_reg(REG_COLOR_LEVEL, CFG_DATA_W'(clvl));
        write_reg(REG_BRIGHT_LEVEL, CFG_DATA_W'(blvl));
        write_reg(REG_FRAME_WIDTH, wraw);
        write_reg(REG_FRAME_HEIGHT, hraw);
    endtask

    // n_pixels below w*h leaves the frame open, without the flush tail
    task automatic run_frame(int w, int h, int pause_at, int n_pixels);
        for (int i = 0; i < n_pixels; i++) begin
            if (i == pause_at) drain(0);
            if ($urandom_range(99) < 5) send_item(OP_FLUSH, random_pixel());
            send_item(OP_PIXEL, random_pixel());
        end
        if (n_pixels == w * h) begin
            for (int i = 0; i < 2 * w + 2; i++) begin
                send_item(1'($urandom_range(1)), random_pixel());
            end
        end
    endtask

    // open a frame at the default geometry, then shrink it and keep the
    // default thresholds and target
    task automatic test_reset_defaults();
        send_idle_pct = 0;
        stall_pct     = 0;
        run_frame(640, 480, -1, 200);
        drain(SETTLE_CYCLES);
        write_reg(REG_FRAME_WIDTH, 12'd8);
        write_reg(REG_FRAME_HEIGHT, 12'd6);
        run_frame(8, 6, -1, 48);
    endtask

    task automatic test_threshold_edges();
        logic [23:0] edge_px [8];
        send_idle_pct = 20;
        stall_pct     = 20;
        // {red, green, blue}
        edge_px[0] = {8'd0,   8'd255, 8'd255};
        edge_px[1] = {8'd255, 8'd41,  8'd0};
        edge_px[2] = {8'd100, 8'd255, 8'd0};
        edge_px[3] = {8'd101, 8'd255, 8'd0};
        edge_px[4] = {8'd255, 8'd0,   8'd0};
        edge_px[5] = {8'd255, 8'd42,  8'd0};
        edge_px[6] = {8'd0,   8'd0,   8'd0};
        edge_px[7] = {8'd255, 8'd255, 8'd255};
        configure(1'b0, 8'd100, 8'd100, 12'd8, 12'd1);
        send_item(OP_FLUSH, 24'hFFFFFF);
        for (int i = 0; i < 8; i++) send_item(OP_PIXEL, edge_px[i]);
        for (int i = 0; i < 18; i++) begin
            send_item((i % 2 == 0) ? OP_FLUSH : OP_PIXEL, 24'hFF00FF);
        end
    endtask

    task automatic test_blue_target();
        send_idle_pct = 30;
        stall_pct     = 30;
        configure(1'b1, 8'd100, 8'd100, 12'd6, 12'd4);
        run_frame(6, 4, -1, 24);
        configure(1'b1, 8'd0, 8'd0, 12'd6, 12'd4);
        run_frame(6, 4, -1, 24);
        configure(1'b1, 8'd255, 8'd255, 12'd5, 12'd3);
        run_frame(5, 3, -1, 15);
        configure(1'b0, 8'd0, 8'd0, 12'd7, 12'd3);
        run_frame(7, 3, -1, 21);
        configure(1'b0, 8'd255, 8'd255, 12'd4, 12'd4);
        run_frame(4, 4, -1, 16);
    endtask

    task automatic test_frame_size_limits();
        send_idle_pct = 0;
        stall_pct     = 0;
        configure(1'b0, 8'd30, 8'd30, 12'd0, 12'd0);
        run_frame(1, 1, -1, 1);
        configure(1'b1, 8'd30, 8'd30, 12'd1, 12'd1);
        run_frame(1, 1, -1, 1);
        configure(1'b0, 8'd60, 8'd40, 12'd1, 12'd4095);
        run_frame(1, ROWS_MAX, -1, 60);
        configure(1'b0, 8'd60, 8'd40, 12'd4095, 12'd1);
        run_frame(LINE_MAX, 1, -1, 60);
    endtask

    task automatic test_geometry_restart();
        send_idle_pct = 25;
        stall_pct     = 25;
        configure(1'b0, 8'd40, 8'd40, 12'd6, 12'd5);
        run_frame(6, 5, -1, 17);
        configure(1'b0, 8'd40, 8'd40, 12'd5, 12'd5);
        run_frame(5, 5, -1, 25);
        run_frame(5, 5, -1, 9);
        drain(SETTLE_CYCLES);
        write_reg(REG_FRAME_HEIGHT, 12'd4);
        run_frame(5, 4, -1, 20);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        configure(1'b0, 8'd60, 8'd60, 12'd10, 12'd6);
        hold_off = 300;
        run_frame(10, 6, 40, 60);
    endtask

    task automatic test_random_frames();
        int w;
        int h;
        int n;
        int sent;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 74; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            sent = 0;
            while (sent < 50) begin
                w = ($urandom_range(7) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
                h = $urandom_range(8, 1);
                configure(1'($urandom_range(1)),
                          8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(120)),
                          8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(120)),
                          12'((w == 1 && $urandom_range(1) == 1) ? 0 : w),
                          12'((h == 1 && $urandom_range(1) == 1) ? 0 : h));
                n = ($urandom_range(9) == 0) ? $urandom_range(w * h - 1) : w * h;
                run_frame(w, h, -1, n);
                sent += n + ((n == w * h) ? 2 * w + 2 : 0);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_threshold_edges();
        test_blue_target();
        test_frame_size_limits();
        test_geometry_restart();
        test_backpressure();
        test_random_frames();
        drain(SETTLE_CYCLES);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
